// ===== rtl/cps_pkg.sv =====
// shared types and constants of the contactor precharge supervisor
package cps_pkg;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned FAULT_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SENSE_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_FIRST_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_STEADY_LIMIT = 3'd4;

  localparam logic [LIMIT_W-1:0] SENSE_LIMIT_RST      = 16'd100;
  localparam logic [LIMIT_W-1:0] SETTLE_LIMIT_RST     = 16'd100;
  localparam logic [LIMIT_W-1:0] MISMATCH_LIMIT_RST   = 16'd10;
  localparam logic [LIMIT_W-1:0] PRE_FIRST_LIMIT_RST  = 16'd1000;
  localparam logic [LIMIT_W-1:0] PRE_STEADY_LIMIT_RST = 16'd100;

  localparam int unsigned FLT_ENABLE_LOSS = 0;
  localparam int unsigned FLT_MAIN_SENSE  = 1;
  localparam int unsigned FLT_MAIN_TMO    = 2;
  localparam int unsigned FLT_PRE_SENSE   = 3;
  localparam int unsigned FLT_PRE_TMO     = 4;

  typedef struct packed {
    logic main_request;
    logic main_sense;
    logic pchg_ready;
    logic pchg_sense;
    logic external_fault;
  } cps_in_t;

  typedef struct packed {
    logic               pre_drive;
    logic               sense_lamp;
    logic               timeout_lamp;
    logic [FAULT_W-1:0] fault_set;
    logic               main_is_closed;
    logic               pre_is_closed;
  } cps_out_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] sense_limit;
    logic [LIMIT_W-1:0] settle_limit;
    logic [LIMIT_W-1:0] mismatch_limit;
    logic [LIMIT_W-1:0] pre_first_limit;
    logic [LIMIT_W-1:0] pre_steady_limit;
  } cps_cfg_t;

  typedef struct packed {
    logic start;
    logic stop;
  } cps_tmr_ctl_t;

endpackage

// ===== rtl/cps_in_if.sv =====
// request channel carrying one sampled tick
interface cps_in_if;
  logic             valid;
  logic             ready;
  cps_pkg::cps_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cps_out_if.sv =====
// result channel carrying the supervisor outputs of one tick
interface cps_out_if;
  logic              valid;
  logic              ready;
  cps_pkg::cps_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cps_cfg_regs.sv =====
// limit registers written through the configuration port
module cps_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cps_pkg::LIMIT_W-1:0]       cfg_data_i,
  output cps_pkg::cps_cfg_t                 cfg_o
);
  import cps_pkg::*;

  cps_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sense_limit      <= SENSE_LIMIT_RST;
      cfg_q.settle_limit     <= SETTLE_LIMIT_RST;
      cfg_q.mismatch_limit   <= MISMATCH_LIMIT_RST;
      cfg_q.pre_first_limit  <= PRE_FIRST_LIMIT_RST;
      cfg_q.pre_steady_limit <= PRE_STEADY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SENSE_LIMIT:      cfg_q.sense_limit      <= cfg_data_i;
        REG_SETTLE_LIMIT:     cfg_q.settle_limit     <= cfg_data_i;
        REG_MISMATCH_LIMIT:   cfg_q.mismatch_limit   <= cfg_data_i;
        REG_PRE_FIRST_LIMIT:  cfg_q.pre_first_limit  <= cfg_data_i;
        REG_PRE_STEADY_LIMIT: cfg_q.pre_steady_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/cps_timer.sv =====
// saturating millisecond timer with start and stop control
module cps_timer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  cps_pkg::cps_tmr_ctl_t    ctl_i,
  output logic [TIMER_BITS-1:0]    cnt_o,
  output logic                     run_o
);
  import cps_pkg::*;

  logic [TIMER_BITS-1:0] cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic [TIMER_BITS-1:0] cnt_tick;

  // count this tick before supervision looks at it
  assign cnt_tick = (run_q && (cnt_q != {TIMER_BITS{1'b1}})) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    cnt_d = cnt_tick;
    run_d = run_q;
    if (ctl_i.stop) begin
      cnt_d = '0;
      run_d = 1'b0;
    end else if (ctl_i.start) begin
      cnt_d = '0;
      run_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  assign cnt_o = cnt_tick;
  assign run_o = run_q;
endmodule

// ===== rtl/cps_core.sv =====
// supervision state and per-tick update of contactor status and faults
module cps_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cps_pkg::cps_in_t    item_i,
  input  cps_pkg::cps_cfg_t   cfg_i,
  output cps_pkg::cps_out_t   res_o
);
  import cps_pkg::*;

  localparam int unsigned CW = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  logic               main_closed_q, main_closed_d;
  logic               pre_closed_q, pre_closed_d;
  logic               drive_q, drive_d;
  logic [FAULT_W-1:0] faults_q, faults_d;
  logic [1:0]         lamps_q, lamps_d;

  cps_tmr_ctl_t          main_ctl, settle_ctl, wait_ctl, psense_ctl;
  logic [TIMER_BITS-1:0] main_cnt, settle_cnt, wait_cnt, psense_cnt;
  logic                  main_run, settle_run, wait_run, psense_run;

  cps_timer #(.TIMER_BITS(TIMER_BITS)) u_main_tmr (
    .clk_i, .rst_ni, .en_i, .ctl_i(main_ctl), .cnt_o(main_cnt), .run_o(main_run)
  );
  cps_timer #(.TIMER_BITS(TIMER_BITS)) u_settle_tmr (
    .clk_i, .rst_ni, .en_i, .ctl_i(settle_ctl), .cnt_o(settle_cnt), .run_o(settle_run)
  );
  cps_timer #(.TIMER_BITS(TIMER_BITS)) u_wait_tmr (
    .clk_i, .rst_ni, .en_i, .ctl_i(wait_ctl), .cnt_o(wait_cnt), .run_o(wait_run)
  );
  cps_timer #(.TIMER_BITS(TIMER_BITS)) u_psense_tmr (
    .clk_i, .rst_ni, .en_i, .ctl_i(psense_ctl), .cnt_o(psense_cnt), .run_o(psense_run)
  );

  logic main_gt_sense, main_gt_mis, settle_gt, psense_gt_sense;
  logic wait_gt_steady, wait_gt_first;

  assign main_gt_sense   = CW'(main_cnt)   > CW'(cfg_i.sense_limit);
  assign main_gt_mis     = CW'(main_cnt)   > CW'(cfg_i.mismatch_limit);
  assign settle_gt       = CW'(settle_cnt) > CW'(cfg_i.settle_limit);
  assign psense_gt_sense = CW'(psense_cnt) > CW'(cfg_i.sense_limit);
  assign wait_gt_steady  = CW'(wait_cnt)   > CW'(cfg_i.pre_steady_limit);
  assign wait_gt_first   = CW'(wait_cnt)   > CW'(cfg_i.pre_first_limit);

  always_comb begin
    logic mismatch;
    logic wait_fresh;
    mismatch      = 1'b0;
    wait_fresh    = 1'b0;
    main_ctl      = '0;
    settle_ctl    = '0;
    wait_ctl      = '0;
    psense_ctl    = '0;
    main_closed_d = main_closed_q;
    pre_closed_d  = pre_closed_q;
    drive_d       = drive_q;
    faults_d      = faults_q;
    lamps_d       = lamps_q;

    if ((faults_q != '0) || item_i.external_fault) begin
      drive_d = 1'b0;
      if (faults_q[FLT_ENABLE_LOSS] || faults_q[FLT_MAIN_SENSE] || faults_q[FLT_PRE_SENSE]) begin
        lamps_d[0] = 1'b1;
      end
      if (faults_q[FLT_ENABLE_LOSS] || faults_q[FLT_MAIN_TMO] || faults_q[FLT_PRE_TMO]) begin
        lamps_d[1] = 1'b1;
      end
    end else begin
      if (item_i.main_request && !main_closed_q) begin
        if (!main_run) begin
          main_ctl.start = 1'b1;
        end else if (!item_i.main_sense && main_gt_sense) begin
          faults_d[FLT_MAIN_SENSE] = 1'b1;
        end else if (item_i.main_sense) begin
          if (!settle_run) begin
            settle_ctl.start = 1'b1;
          end else if (settle_gt) begin
            main_closed_d    = 1'b1;
            main_ctl.stop    = 1'b1;
            settle_ctl.stop  = 1'b1;
            wait_ctl.start   = 1'b1;
            wait_fresh       = 1'b1;
          end
        end
      end else if (!item_i.main_request && main_closed_q) begin
        if (!main_run) begin
          main_ctl.start = 1'b1;
        end else if (main_gt_mis) begin
          faults_d[FLT_ENABLE_LOSS] = 1'b1;
        end
      end else begin
        mismatch = item_i.main_request ? !item_i.main_sense : item_i.main_sense;
        if (mismatch) begin
          if (!main_run) begin
            main_ctl.start = 1'b1;
          end else if (main_gt_mis) begin
            faults_d[FLT_MAIN_SENSE] = 1'b1;
          end
        end else begin
          main_ctl.stop = 1'b1;
        end
      end

      // a wait timer started this tick reads zero and cannot fire yet
      if (main_closed_d) begin
        if (!item_i.pchg_ready) begin
          if (!(wait_run || wait_fresh)) begin
            wait_ctl.start = 1'b1;
          end else if (!wait_fresh && pre_closed_q && wait_gt_steady) begin
            faults_d[FLT_PRE_TMO] = 1'b1;
          end else if (!wait_fresh && wait_gt_first) begin
            faults_d[FLT_PRE_TMO] = 1'b1;
          end
        end else begin
          drive_d = 1'b1;
          if (!psense_run) begin
            psense_ctl.start = 1'b1;
          end else if (!item_i.pchg_sense && psense_gt_sense) begin
            faults_d[FLT_PRE_SENSE] = 1'b1;
          end else if (item_i.pchg_sense) begin
            pre_closed_d    = 1'b1;
            psense_ctl.stop = 1'b1;
            wait_ctl.stop   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_closed_q <= 1'b0;
      pre_closed_q  <= 1'b0;
      drive_q       <= 1'b0;
      faults_q      <= '0;
      lamps_q       <= '0;
    end else if (en_i) begin
      main_closed_q <= main_closed_d;
      pre_closed_q  <= pre_closed_d;
      drive_q       <= drive_d;
      faults_q      <= faults_d;
      lamps_q       <= lamps_d;
    end
  end

  assign res_o.pre_drive      = drive_d;
  assign res_o.sense_lamp     = lamps_d[0];
  assign res_o.timeout_lamp   = lamps_d[1];
  assign res_o.fault_set      = faults_d;
  assign res_o.main_is_closed = main_closed_d;
  assign res_o.pre_is_closed  = pre_closed_d;
endmodule

// ===== rtl/contactor_precharge_supervisor_top.sv =====
// top level of the contactor precharge supervisor
// pipeline: a request accepted is held in the input register, then its result in the result register
// throughput: one request per cycle while the result side is ready, set by the input register and result register
// stalls: while a result waits the input stage takes one more request, then holds
// reset: asynchronous active low, clears the limits to their defaults, all timers,
// faults, lamps and contactor status
module contactor_precharge_supervisor_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cps_pkg::LIMIT_W-1:0]   cfg_data_i,
  cps_in_if.sink                        in_req,
  cps_out_if.source                     out_res
);
  import cps_pkg::*;

  cps_cfg_t cfg;
  cps_in_t  item_q;
  logic     item_vld_q;
  cps_out_t res_d, res_q;
  logic     res_vld_q;
  logic     advance;

  cps_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  assign advance      = item_vld_q && (!res_vld_q || out_res.ready);
  assign in_req.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_req.ready) begin
      item_vld_q <= in_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req.ready && in_req.valid) begin
      item_q <= in_req.data;
    end
  end

  cps_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk_i, .rst_ni, .en_i(advance), .item_i(item_q), .cfg_i(cfg), .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (out_res.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_res.valid = res_vld_q;
  assign out_res.data  = res_q;
endmodule

// ===== dv/tb_contactor_precharge_supervisor_top.sv =====
// self-checking testbench of the contactor precharge supervisor top level
`timescale 1ns / 100ps

module tb_contactor_precharge_supervisor_top;
  import cps_pkg::*;

  localparam int unsigned TMR_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 150;
  localparam int unsigned HOLD_TICKS = 2060;
  localparam int unsigned MAX_REPORTS = 50;
  localparam cps_out_t ALL_OPEN = '0;

  typedef enum int unsigned {
    FINAL_ENABLE_LOSS,
    FINAL_SENSE_PAIR,
    FINAL_PRE_TIMEOUT
  } final_fault_e;

  typedef struct {
    cps_in_t     tick;
    int unsigned reps;
    bit          typed;
    cps_out_t    want;
    bit          closing_cfg;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [LIMIT_W-1:0]   cfg_data;

  cps_in_if  in_ch ();
  cps_out_if out_ch ();

  contactor_precharge_supervisor_top #(
    .TIMER_BITS (TMR_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_req     (in_ch),
    .out_res    (out_ch)
  );

  // supervisor state as predicted
  cps_cfg_t           lim;
  bit                 mc, pc, drv, lamp_s, lamp_t;
  bit                 run_main, run_settle, run_wait, run_psense;
  logic [TMR_W-1:0]   t_main, t_settle, t_wait, t_psense;
  logic [FAULT_W-1:0] faults;

  cps_out_t     pending_status[$];
  dir_row_t     dir_rows[$];
  bit           full_rate;
  int unsigned  n_errors;
  int unsigned  n_sent;
  int unsigned  n_checked;
  final_fault_e final_kind;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("tb_contactor_precharge_supervisor_top failed");
    $finish;
  end

  function automatic cps_in_t tick(bit req, bit ms, bit rdy, bit ps, bit ext);
    cps_in_t d;
    d.main_request   = req;
    d.main_sense     = ms;
    d.pchg_ready     = rdy;
    d.pchg_sense     = ps;
    d.external_fault = ext;
    return d;
  endfunction

  function automatic logic [TMR_W-1:0] bump(logic [TMR_W-1:0] t, bit run);
    return (run && t != '1) ? t + 1'b1 : t;
  endfunction

  task automatic step_supervisor(input cps_in_t d, output cps_out_t r);
    bit mism;
    t_main   = bump(t_main, run_main);
    t_settle = bump(t_settle, run_settle);
    t_wait   = bump(t_wait, run_wait);
    t_psense = bump(t_psense, run_psense);
    if (faults != '0 || d.external_fault) begin
      drv = 1'b0;
      if (faults[FLT_ENABLE_LOSS]) begin
        lamp_s = 1'b1;
        lamp_t = 1'b1;
      end
      if (faults[FLT_MAIN_SENSE] || faults[FLT_PRE_SENSE]) lamp_s = 1'b1;
      if (faults[FLT_MAIN_TMO] || faults[FLT_PRE_TMO]) lamp_t = 1'b1;
    end else begin
      if (d.main_request && !mc) begin
        if (!run_main) begin
          t_main = '0;
          run_main = 1'b1;
        end else if (!d.main_sense && t_main > lim.sense_limit) begin
          faults[FLT_MAIN_SENSE] = 1'b1;
        end else if (d.main_sense) begin
          if (!run_settle) begin
            t_settle = '0;
            run_settle = 1'b1;
          end else if (t_settle > lim.settle_limit) begin
            mc = 1'b1;
            t_main = '0;
            run_main = 1'b0;
            t_settle = '0;
            run_settle = 1'b0;
            t_wait = '0;
            run_wait = 1'b1;
          end
        end
      end else if (!d.main_request && mc) begin
        if (!run_main) begin
          t_main = '0;
          run_main = 1'b1;
        end else if (t_main > lim.mismatch_limit) begin
          faults[FLT_ENABLE_LOSS] = 1'b1;
        end
      end else begin
        mism = d.main_request ? !d.main_sense : d.main_sense;
        if (!mism) begin
          t_main = '0;
          run_main = 1'b0;
        end else if (!run_main) begin
          t_main = '0;
          run_main = 1'b1;
        end else if (t_main > lim.mismatch_limit) begin
          faults[FLT_MAIN_SENSE] = 1'b1;
        end
      end

      if (mc) begin
        if (!d.pchg_ready) begin
          if (!run_wait) begin
            t_wait = '0;
            run_wait = 1'b1;
          end else if (pc && t_wait > lim.pre_steady_limit) begin
            faults[FLT_PRE_TMO] = 1'b1;
          end else if (t_wait > lim.pre_first_limit) begin
            faults[FLT_PRE_TMO] = 1'b1;
          end
        end else begin
          drv = 1'b1;
          if (!run_psense) begin
            t_psense = '0;
            run_psense = 1'b1;
          end else if (!d.pchg_sense && t_psense > lim.sense_limit) begin
            faults[FLT_PRE_SENSE] = 1'b1;
          end else if (d.pchg_sense) begin
            pc = 1'b1;
            t_psense = '0;
            run_psense = 1'b0;
            t_wait = '0;
            run_wait = 1'b0;
          end
        end
      end
    end
    r.pre_drive      = drv;
    r.sense_lamp     = lamp_s;
    r.timeout_lamp   = lamp_t;
    r.fault_set      = faults;
    r.main_is_closed = mc;
    r.pre_is_closed  = pc;
  endtask

  task automatic send_tick(input cps_in_t d, input bit typed, input cps_out_t want);
    int unsigned gap;
    cps_out_t    pred;
    gap = full_rate ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    step_supervisor(d, pred);
    pending_status.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      REG_SENSE_LIMIT:      lim.sense_limit      = val;
      REG_SETTLE_LIMIT:     lim.settle_limit     = val;
      REG_MISMATCH_LIMIT:   lim.mismatch_limit   = val;
      REG_PRE_FIRST_LIMIT:  lim.pre_first_limit  = val;
      REG_PRE_STEADY_LIMIT: lim.pre_steady_limit = val;
      default: ;
    endcase
  endtask

  // only while nothing is in flight
  task automatic apply_limits(input cps_cfg_t c);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    cfg_write(REG_SENSE_LIMIT, c.sense_limit);
    cfg_write(REG_SETTLE_LIMIT, c.settle_limit);
    cfg_write(REG_MISMATCH_LIMIT, c.mismatch_limit);
    cfg_write(REG_PRE_FIRST_LIMIT, c.pre_first_limit);
    cfg_write(REG_PRE_STEADY_LIMIT, c.pre_steady_limit);
    cfg_write(REG_UNUSED, LIMIT_W'($urandom_range(0, 65535)));
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [FAULT_W-1:0] want,
                             input logic [FAULT_W-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // result side
  initial begin
    int unsigned gap;
    cps_out_t    got, want;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = full_rate ? 0 : $urandom_range(0, 18);
      @(negedge clk_i);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = out_ch.data;
      if (pending_status.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected result %0h", $time, got);
      end else begin
        want = pending_status.pop_front();
        check_field("pre_drive", FAULT_W'(want.pre_drive), FAULT_W'(got.pre_drive));
        check_field("sense_lamp", FAULT_W'(want.sense_lamp), FAULT_W'(got.sense_lamp));
        check_field("timeout_lamp", FAULT_W'(want.timeout_lamp),
                    FAULT_W'(got.timeout_lamp));
        check_field("fault_set", want.fault_set, got.fault_set);
        check_field("main_is_closed", FAULT_W'(want.main_is_closed),
                    FAULT_W'(got.main_is_closed));
        check_field("pre_is_closed", FAULT_W'(want.pre_is_closed),
                    FAULT_W'(got.pre_is_closed));
        n_checked++;
      end
    end
  end

  // request side
  initial begin
    dir_row_t row;
    cps_cfg_t c;
    cps_in_t  d;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_SENSE_LIMIT;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    full_rate   = 1'b0;
    n_errors    = 0;
    n_sent      = 0;
    n_checked   = 0;
    lim.sense_limit      = SENSE_LIMIT_RST;
    lim.settle_limit     = SETTLE_LIMIT_RST;
    lim.mismatch_limit   = MISMATCH_LIMIT_RST;
    lim.pre_first_limit  = PRE_FIRST_LIMIT_RST;
    lim.pre_steady_limit = PRE_STEADY_LIMIT_RST;
    {mc, pc, drv, lamp_s, lamp_t} = '0;
    {run_main, run_settle, run_wait, run_psense} = '0;
    {t_main, t_settle, t_wait, t_psense} = '0;
    faults = '0;

    // after reset: idle, external fault alone, all pins high, mismatch just under limit
    dir_rows.push_back('{tick(0, 0, 0, 0, 0), 1, 1'b1, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(0, 0, 0, 0, 1), 1, 1'b1, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(1, 1, 1, 1, 1), 1, 1'b1, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(0, 1, 0, 0, 0), 11, 1'b1, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(0, 0, 1, 1, 0), 1, 1'b1, ALL_OPEN, 1'b0});
    // closing of main then precharge with a short settle
    dir_rows.push_back('{tick(1, 0, 0, 0, 0), 2, 1'b0, ALL_OPEN, 1'b1});
    dir_rows.push_back('{tick(1, 1, 0, 0, 0), 4, 1'b0, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(1, 1, 0, 1, 0), 1, 1'b0, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(1, 1, 1, 0, 0), 2, 1'b0, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(1, 1, 1, 1, 0), 1, 1'b0, ALL_OPEN, 1'b0});
    dir_rows.push_back('{tick(1, 1, 1, 1, 1), 1, 1'b0, ALL_OPEN, 1'b0});

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.closing_cfg) begin
        c = lim;
        c.settle_limit = 16'd1;
        apply_limits(c);
      end
      repeat (row.reps) send_tick(row.tick, row.typed, row.want);
    end

    // mostly steady closed operation with glitches and noise
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        c = '1;
      end else begin
        c.sense_limit      = LIMIT_W'($urandom_range(300, 65535));
        c.settle_limit     = (ph == 0) ? LIMIT_W'($urandom_range(0, 20)) : '0;
        c.mismatch_limit   = LIMIT_W'($urandom_range(300, 65535));
        c.pre_first_limit  = LIMIT_W'($urandom_range(300, 65535));
        c.pre_steady_limit = LIMIT_W'($urandom_range(300, 65535));
      end
      apply_limits(c);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 64 == 0) full_rate = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
          d = cps_in_t'($urandom_range(0, 31));
        else
          d = tick(1, 1, $urandom_range(0, 5) != 0, $urandom_range(0, 3) != 0, 0);
        send_tick(d, 1'b0, ALL_OPEN);
      end
    end

    // long mismatch with the largest limits: timers saturate and never fire
    full_rate = 1'b0;
    c = '1;
    apply_limits(c);
    full_rate = 1'b1;
    repeat (HOLD_TICKS) send_tick(tick(1, 0, 1, 0, 0), 1'b0, ALL_OPEN);

    // zero limits: latch faults, then noise on the latched state
    full_rate = 1'b0;
    c = '0;
    apply_limits(c);
    final_kind = final_fault_e'($urandom_range(FINAL_ENABLE_LOSS, FINAL_PRE_TIMEOUT));
    case (final_kind)
      FINAL_ENABLE_LOSS: d = tick(0, 1, 0, 1, 0);
      FINAL_SENSE_PAIR:  d = tick(1, 0, 1, 0, 0);
      default:           d = tick(1, 1, 0, 0, 0);
    endcase
    repeat (4) send_tick(d, 1'b0, ALL_OPEN);
    repeat (100) send_tick(cps_in_t'($urandom_range(0, 31)), 1'b0, ALL_OPEN);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d ticks sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_errors);
    $display("closing, steady operation, %0d tick saturation hold, final fault %s",
             HOLD_TICKS, final_kind.name());
    if (n_errors == 0) begin
      $display("tb_contactor_precharge_supervisor_top passed");
    end else begin
      $display("tb_contactor_precharge_supervisor_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cps_pkg.sv
rtl/cps_in_if.sv
rtl/cps_out_if.sv
rtl/cps_cfg_regs.sv
rtl/cps_timer.sv
rtl/cps_core.sv
rtl/contactor_precharge_supervisor_top.sv
dv/tb_contactor_precharge_supervisor_top.sv
